@@ hw/rtl/seven_segment_scan_driver_macros.svh @@
// Assertion macros for the scan driver top level.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define SSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/ssd_pkg.sv @@
// Package with types, codes and the segment pattern table of the scan driver.
`default_nettype none
package ssd_pkg;

  localparam int unsigned PinW   = 12;
  localparam int unsigned DigitW = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned ModW   = 10;  // value modulo 1000 fits in ten bits

  localparam int unsigned DotPin = 9;

  // Event kinds carried in the input tuser bit.
  localparam logic ACT_SCAN  = 1'b0;
  localparam logic ACT_BLANK = 1'b1;

  // Scan phases that light a digit.
  localparam logic [DigitW-1:0] PH_SYMBOL = 3'd1;
  localparam logic [DigitW-1:0] PH_HUNDS  = 3'd2;
  localparam logic [DigitW-1:0] PH_TENS   = 3'd3;
  localparam logic [DigitW-1:0] PH_UNITS  = 3'd4;

  typedef struct packed {
    logic              action;
    logic [ModW-1:0]   value_mod;
    logic [3:0]        symbol;
    logic [3:0]        dot_mask;
  } ssd_item_t;

  // Pin pattern for one glyph index; indexes past the table give no pins.
  function automatic logic [PinW-1:0] seg_pattern(input logic [3:0] idx);
    logic [PinW-1:0] pat;
    unique case (idx)
      4'd0:    pat = 12'h280;
      4'd1:    pat = 12'hE8A;
      4'd2:    pat = 12'h30C;
      4'd3:    pat = 12'hA0C;
      4'd4:    pat = 12'hE06;
      4'd5:    pat = 12'hA24;
      4'd6:    pat = 12'h224;
      4'd7:    pat = 12'hE8C;
      4'd8:    pat = 12'h204;
      4'd9:    pat = 12'hA04;
      4'd10:   pat = 12'hFAA;
      4'd11:   pat = 12'h704;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ssd_in_stage.sv @@
// Input register of the scan driver; reduces the value modulo 1000 on entry.
`default_nettype none
module ssd_in_stage
  import ssd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  input  wire logic [ValueW-1:0]   value_i,
  input  wire logic [3:0]          symbol_i,
  input  wire logic [3:0]          dot_mask_i,
  output logic                     item_valid_o,
  input  wire logic                item_ready_i,
  output ssd_item_t                item_o
);

  logic            vld_q, vld_d;
  ssd_item_t       item_q;
  logic [32:0]     prod;
  logic [6:0]      quot;
  logic [16:0]     quot_k;
  logic [ModW-1:0] value_mod;
  logic            accept;

  // Quotient by 1000 through the reciprocal 67109 / 2^26, exact for 16-bit values.
  assign prod   = {17'd0, value_i} * 33'd67109;
  assign quot   = prod[32:26];
  // quot * 1000 as shifts and adds.
  assign quot_k = ({10'd0, quot} << 10) - ({10'd0, quot} << 4) - ({10'd0, quot} << 3);
  assign value_mod = ModW'({1'b0, value_i} - quot_k);

  assign in_ready_o   = !vld_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action    <= action_i;
      item_q.value_mod <= value_mod;
      item_q.symbol    <= symbol_i;
      item_q.dot_mask  <= dot_mask_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ssd_scan_core.sv @@
// Scan phase, pin and digit state of the driver; the state doubles as output register.
`default_nettype none
module ssd_scan_core
  import ssd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire ssd_item_t          item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [PinW-1:0]         pins_o,
  output logic [DigitW-1:0]       digit_o
);

  logic [DigitW-1:0] phase_q, phase_d;
  logic [PinW-1:0]   pins_q, pins_d;
  logic [DigitW-1:0] digit_q, digit_d;
  logic              out_vld_q, out_vld_d;
  logic              advance;

  logic [DigitW-1:0] ph;
  logic [15:0]       hund_prod;
  logic [3:0]        hunds;
  logic [6:0]        rem100;
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [3:0]        units;
  logic [3:0]        idx;
  logic [PinW-1:0]   pins_or;

  assign item_ready_o = !out_vld_q || out_ready_i;
  assign advance      = item_valid_i && item_ready_o;

  // Digits of a value below 1000 by constant reciprocals, written as shifts and adds.
  assign hund_prod = ({6'd0, item_i.value_mod} << 5) + ({6'd0, item_i.value_mod} << 3)
                   + {6'd0, item_i.value_mod};
  assign hunds     = hund_prod[15:12];
  assign rem100    = 7'(item_i.value_mod - (({6'd0, hunds} << 6) + ({6'd0, hunds} << 5)
                   + ({6'd0, hunds} << 2)));
  assign tens_prod = ({8'd0, rem100} << 7) + ({8'd0, rem100} << 6) + ({8'd0, rem100} << 3)
                   + ({8'd0, rem100} << 2) + {8'd0, rem100};
  assign tens      = tens_prod[14:11];
  assign units     = 4'(rem100 - (({3'd0, tens} << 3) + ({3'd0, tens} << 1)));

  assign ph = phase_q + 3'd1;

  always_comb begin
    unique case (ph)
      PH_SYMBOL: idx = item_i.symbol;
      PH_HUNDS:  idx = hunds;
      PH_TENS:   idx = tens;
      default:   idx = units;
    endcase
  end

  assign pins_or = pins_q | seg_pattern(idx);

  always_comb begin
    phase_d   = phase_q;
    pins_d    = pins_q;
    digit_d   = digit_q;
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
      if (item_i.action == ACT_BLANK) begin
        pins_d  = '0;
        digit_d = '0;
      end else if (ph >= PH_SYMBOL && ph <= PH_UNITS) begin
        pins_d = pins_or;
        // The dot pin is active low, so a lit dot clears it after the pattern.
        if (item_i.dot_mask[phase_q[1:0]]) begin
          pins_d[DotPin] = 1'b0;
        end
        digit_d = ph;
        phase_d = ph;
      end else begin
        phase_d = '0;
      end
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      pins_q    <= '0;
      digit_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pins_q    <= pins_d;
      digit_q   <= digit_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pins_o      = pins_q;
  assign digit_o     = digit_q;

endmodule
`default_nettype wire

@@ hw/rtl/seven_segment_scan_driver.sv @@
// Top level of the multiplexed four-digit seven-segment scan driver.
//
//  Channel  Dir  tdata (low bit first)                    tuser
//  s_axis   in   value[15:0] symbol[19:16] dot_mask[23:20]  action
//  m_axis   out  segment_pins[11:0] digit_select[14:12]    -
//
// Each event word passes an input register, where the value is reduced modulo 1000
// by one reciprocal multiplier, then the scan state register, which is also the
// output register; it takes one word per cycle while the output is not stalled.
// A stalled output holds its word; the input register still takes one more word.
// Reset clears the phase, the pins and the digit enable.
`default_nettype none
`include "seven_segment_scan_driver_macros.svh"
module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // value, symbol, dot_mask
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // segment_pins, digit_select, zero fill
);

  logic              mid_valid;
  logic              mid_ready;
  ssd_item_t         mid_item;
  logic [PinW-1:0]   pins;
  logic [DigitW-1:0] digit;

  ssd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .value_i      (s_axis_tdata[15:0]),
    .symbol_i     (s_axis_tdata[19:16]),
    .dot_mask_i   (s_axis_tdata[23:20]),
    .item_valid_o (mid_valid),
    .item_ready_i (mid_ready),
    .item_o       (mid_item)
  );

  ssd_scan_core u_scan_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (mid_valid),
    .item_ready_o (mid_ready),
    .item_i       (mid_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pins_o       (pins),
    .digit_o      (digit)
  );

  assign m_axis_tdata = {1'b0, digit, pins};

  `SSD_ASSERT_NEVER(a_digit_range, digit > PH_UNITS, "digit select beyond the fourth digit")
  `SSD_ASSERT(a_dark_when_off, (digit == '0) |-> (pins == '0), "pins lit with no digit enabled")
  `SSD_ASSERT(a_out_from_mid, $rose(m_axis_tvalid) |-> $past(mid_valid), "result without an item")

endmodule
`default_nettype wire

@@ bench/seven_segment_scan_checker.sv @@
// Checker that predicts the scan driver's pin words and compares them at the output.
`timescale 1ns / 100ps
module seven_segment_scan_checker
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // value, symbol, dot_mask
  input  logic        s_axis_tuser,    // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,    // segment_pins, digit_select, zero fill
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          blank_count_o,
  output int          wrap_count_o,
  output int          no_glyph_count_o
);

  typedef struct packed {
    logic [PinW-1:0]   pins;
    logic [DigitW-1:0] digit;
  } display_t;

  // Glyph pin patterns, index 0 in the lowest twelve bits.
  localparam logic [12*PinW-1:0] GLYPH_ROM = {
    12'h704, 12'hFAA, 12'hA04, 12'h204, 12'hE8C, 12'h224,
    12'hA24, 12'hE06, 12'hA0C, 12'h30C, 12'hE8A, 12'h280
  };

  logic [DigitW-1:0] phase_q = '0;
  logic [PinW-1:0]   pins_q  = '0;
  logic [DigitW-1:0] digit_q = '0;
  display_t          display_q[$];

  initial begin
    fail_count_o     = 0;
    pending_o        = 0;
    checked_o        = 0;
    blank_count_o    = 0;
    wrap_count_o     = 0;
    no_glyph_count_o = 0;
  end

  function automatic logic [PinW-1:0] glyph_pins(input logic [3:0] idx);
    if (idx < 4'd12) begin
      return GLYPH_ROM[idx*PinW +: PinW];
    end
    return '0;
  endfunction

  task automatic predict_display(input logic act, input logic [15:0] val,
                                 input logic [3:0] sym, input logic [3:0] dots);
    logic [DigitW-1:0] ph;
    int unsigned       shown;
    logic [3:0]        idx;
    if (act == ACT_BLANK) begin
      pins_q  = '0;
      digit_q = '0;
      blank_count_o++;
    end else begin
      ph = phase_q + 3'd1;
      if (ph >= PH_SYMBOL && ph <= PH_UNITS) begin
        shown = val % 1000;
        case (ph)
          PH_SYMBOL: idx = sym;
          PH_HUNDS:  idx = 4'(shown / 100);
          PH_TENS:   idx = 4'((shown / 10) % 10);
          default:   idx = 4'(shown % 10);
        endcase
        if (idx >= 4'd12) begin
          no_glyph_count_o++;
        end
        pins_q = pins_q | glyph_pins(idx);
        // The dot is active low and wins over any pattern bit.
        if (dots[ph - 3'd1]) begin
          pins_q[DotPin] = 1'b0;
        end
        digit_q = ph;
        phase_q = ph;
      end else begin
        phase_q = '0;
        wrap_count_o++;
      end
    end
    display_q.push_back('{pins: pins_q, digit: digit_q});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    display_t want;
    if (!rst_ni) begin
      phase_q = '0;
      pins_q  = '0;
      digit_q = '0;
      display_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (display_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("Unexpected output word: pins %03h digit %0d",
                     m_axis_tdata[11:0], m_axis_tdata[14:12]);
          end
          fail_count_o++;
        end else begin
          want = display_q.pop_front();
          if (m_axis_tdata[11:0] !== want.pins || m_axis_tdata[14:12] !== want.digit) begin
            if (fail_count_o < 10) begin
              $display("Mismatch on word %0d: expected pins %03h digit %0d, got pins %03h digit %0d",
                       checked_o, want.pins, want.digit,
                       m_axis_tdata[11:0], m_axis_tdata[14:12]);
            end
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_display(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[19:16],
                        s_axis_tdata[23:20]);
      end
    end
    pending_o <= display_q.size();
  end

endmodule

@@ bench/seven_segment_scan_driver_tb.sv @@
// Testbench top for the scan driver: clock, reset, event stimulus and the verdict.
`timescale 1ns / 100ps
module seven_segment_scan_driver_tb
  import ssd_pkg::*;
();

  localparam int CycleLimit = 100000;
  localparam int HoldCycles = 64;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int blank_count;
  int wrap_count;
  int no_glyph_count;

  int cycle_count  = 0;
  int words_sent   = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  seven_segment_scan_driver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  seven_segment_scan_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .blank_count_o    (blank_count),
    .wrap_count_o     (wrap_count),
    .no_glyph_count_o (no_glyph_count)
  );

  // Output side: random stalls, plus a long hold-off each time one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles - 1;
      hold_seen     <= hold_req;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Ready is sampled at the falling edge, where nothing changes until the next rising edge.
  task automatic send_word(input logic act, input logic [15:0] val,
                           input logic [3:0] sym, input logic [3:0] dots);
    logic rdy;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {dots, sym, val};
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  task automatic scan(input logic [15:0] val, input logic [3:0] sym, input logic [3:0] dots);
    send_word(ACT_SCAN, val, sym, dots);
  endtask

  // The other fields of a blank tick carry noise.
  task automatic blank();
    send_word(ACT_BLANK, 16'($urandom), 4'($urandom), 4'($urandom));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 999));
      2:       return 16'($urandom_range(0, 64) * 1000 + ($urandom_range(0, 1) ? 999 : 0));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic run_random(input int n);
    int         target;
    int         r;
    logic [15:0] val;
    logic [3:0]  sym;
    logic [3:0]  dots;
    target = words_sent + n;
    while (words_sent < target) begin
      r    = $urandom_range(0, 99);
      val  = pick_value();
      sym  = 4'($urandom);
      dots = 4'($urandom);
      if (r < 60) begin
        // Normal refresh: each digit lit and blanked after it, then the tick that wraps the phase.
        for (int k = 0; k < 5; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            val = pick_value();
          end
          scan(val, sym, dots);
          if (k < 4) begin
            blank();
          end
        end
      end else if (r < 85) begin
        for (int k = 0; k < 5; k++) begin
          scan(val, sym, dots);
        end
        blank();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(1'($urandom), 16'($urandom), 4'($urandom), 4'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero value and glyph zero, then the extra tick that wraps the phase.
    repeat (5) scan(16'd0, 4'd0, 4'h0);
    blank();
    // Largest value, a symbol past the table and every dot lit.
    repeat (5) scan(16'hFFFF, 4'd15, 4'hF);
    blank();
    // No blanks in between, so the patterns pile up on the pins.
    scan(16'd999, 4'd10, 4'h5);
    scan(16'd999, 4'd10, 4'h5);
    scan(16'd1000, 4'd11, 4'hA);
    scan(16'd1000, 4'd11, 4'hA);
    scan(16'd1000, 4'd11, 4'hA);
    // A blank in mid-frame leaves the phase where it was.
    scan(16'd478, 4'd12, 4'h0);
    blank();
    scan(16'd478, 4'd13, 4'h2);
    scan(16'd478, 4'd14, 4'h4);
    blank();

    src_idle_pct = 38;
    dst_idle_pct <= 74;
    hold_req     <= hold_req + 1;
    run_random(400);
    src_idle_pct = 74;
    dst_idle_pct <= 38;
    run_random(400);
    src_idle_pct = 0;
    dst_idle_pct <= 0;
    hold_req     <= hold_req + 1;
    run_random(400);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d words from %0d events: %0d blank ticks, %0d phase wraps,",
             checked, words_sent, blank_count, wrap_count);
    $display("%0d glyphs past the table, under three stall mixes and two long output holds.",
             no_glyph_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_in_stage.sv
hw/rtl/ssd_scan_core.sv
hw/rtl/seven_segment_scan_driver.sv
bench/seven_segment_scan_checker.sv
bench/seven_segment_scan_driver_tb.sv
